// ===== rtl/core/lcgrr_pkg.sv =====
// package with shared constants and types for the lcg random generator
`default_nettype none
package lcgrr_pkg;

  // generator width and lcg coefficients
  localparam int unsigned SEED_W       = 32;
  localparam logic [31:0] LCG_MUL      = 32'd214013;
  localparam logic [31:0] LCG_ADD      = 32'd2531011;
  localparam int unsigned SAMPLE_SHIFT = 16;
  localparam int unsigned SAMPLE_BITS_DEFAULT = 15;

  // request commands
  typedef enum logic [1:0] {
    CMD_RAW   = 2'd0,
    CMD_BITS  = 2'd1,
    CMD_RANGE = 2'd2,
    CMD_BOOL  = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/lcgrr_seed.sv =====
// seed register with load from configuration and one lcg advance per request
`default_nettype none
module lcgrr_seed (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic [lcgrr_pkg::SEED_W-1:0]  load_data,
  input  wire logic                          advance,
  output logic      [lcgrr_pkg::SEED_W-1:0]  seed
);

  logic [lcgrr_pkg::SEED_W-1:0] seed_next;

  // seed * a + c, wrapping at the seed width
  always_comb begin
    seed_next = lcgrr_pkg::SEED_W'(seed * lcgrr_pkg::LCG_MUL + lcgrr_pkg::LCG_ADD);
  end

  // load wins over advance; both never come together in normal use
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (load) begin
      seed <= load_data;
    end else if (advance) begin
      seed <= seed_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lcgrr_div.sv =====
// bit-serial restoring remainder unit, one sample bit per cycle
`default_nettype none
module lcgrr_div #(
  parameter int unsigned SAMPLE_BITS = lcgrr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [SAMPLE_BITS-1:0]        sample,
  input  wire logic [lcgrr_pkg::SEED_W-1:0]  divisor,
  output logic                               done,
  output logic      [SAMPLE_BITS-1:0]        rem
);

  localparam int unsigned CNT_W = $clog2(SAMPLE_BITS + 1);

  logic                              busy;
  logic [CNT_W-1:0]                  cnt;
  logic [SAMPLE_BITS-1:0]            shreg;
  logic [SAMPLE_BITS:0]              trial;
  logic [lcgrr_pkg::SEED_W-1:0]      diff;
  logic                              fits;
  logic [SAMPLE_BITS-1:0]            rem_next;
  logic                              last;

  // shift the next dividend bit in and try a subtract
  always_comb begin
    trial    = {rem, shreg[SAMPLE_BITS-1]};
    fits     = lcgrr_pkg::SEED_W'(trial) >= divisor;
    diff     = lcgrr_pkg::SEED_W'(trial) - divisor;
    rem_next = fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
    last     = (cnt == CNT_W'(SAMPLE_BITS - 1));
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= sample;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= rem_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lcg_random_with_range_top.sv =====
// top level of the lcg random generator with shaped results
//
// Usage: write a seed on the cfg channel (cfg_valid/cfg_ready, cfg_data) while
// the block is idle; it loads into the generator at once. Each request on the
// in channel (in_valid/in_ready with command, bit_count, range_low, range_high)
// advances the seed once and yields one result on the out channel
// (out_valid/out_ready with value).
// Each request passes through the load, divide and output states of the
// sequencer, and the bit-serial remainder unit handles one sample bit per cycle.
// One request is worked on at a time, so a new request is taken only once the
// sequencer has returned to idle.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, a finished result holds in the sequencer
// until the output register frees, and no further request is taken.
// Reset clears the seed to zero and empties the output register.
`default_nettype none
module lcg_random_with_range_top #(
  parameter int unsigned SAMPLE_BITS = lcgrr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   command,
  input  wire logic [4:0]   bit_count,
  input  wire logic [31:0]  range_low,
  input  wire logic [31:0]  range_high,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic      [31:0]  value
);

  lcgrr_pkg::state_t state, state_next;

  logic                   in_fire;
  logic                   div_start;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] div_rem;
  logic [31:0]            seed;
  logic [SAMPLE_BITS-1:0] sample;
  lcgrr_pkg::cmd_t        cmd;
  logic [4:0]             nbits;
  logic [31:0]            lo;
  logic [31:0]            divisor;
  logic [31:0]            sample_ext;
  logic [31:0]            result;
  logic                   out_load;

  assign cfg_ready  = 1'b1;
  assign in_fire    = in_valid && in_ready;
  assign sample     = seed[lcgrr_pkg::SAMPLE_SHIFT +: SAMPLE_BITS];
  assign sample_ext = 32'(sample);

  // generator state
  lcgrr_seed u_seed (
    .clk       (clk),
    .rst       (rst),
    .load      (cfg_valid && cfg_ready),
    .load_data (cfg_data),
    .advance   (in_fire),
    .seed      (seed)
  );

  // remainder of the sample by the range width
  lcgrr_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .sample  (sample),
    .divisor (divisor),
    .done    (div_done),
    .rem     (div_rem)
  );

  // request fields held for the duration of the work
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd     <= lcgrr_pkg::cmd_t'(command);
      nbits   <= bit_count;
      lo      <= range_low;
      divisor <= range_high - range_low + 32'd1;
    end
  end

  // shape the sample by command
  always_comb begin
    unique case (cmd)
      lcgrr_pkg::CMD_RAW:   result = sample_ext;
      lcgrr_pkg::CMD_BITS:  result = sample_ext & ~(32'hFFFF_FFFF << nbits);
      lcgrr_pkg::CMD_RANGE: result = lo + ((divisor == 32'd0) ? 32'd0 : 32'(div_rem));
      lcgrr_pkg::CMD_BOOL:  result = {31'd0, sample[0]};
      default:              result = sample_ext;
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcgrr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      lcgrr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = lcgrr_pkg::ST_LOAD;
        end
      end
      lcgrr_pkg::ST_LOAD: begin
        div_start  = 1'b1;
        state_next = lcgrr_pkg::ST_DIV;
      end
      lcgrr_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = lcgrr_pkg::ST_OUT;
        end
      end
      lcgrr_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = lcgrr_pkg::ST_IDLE;
        end
      end
      default: state_next = lcgrr_pkg::ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value <= result;
    end
  end

  // only one request in flight
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("request taken while another is in work");

  // remainder unit finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == lcgrr_pkg::ST_DIV)
    else $error("remainder done outside of divide state");

  // a finished result with a free output register is shown next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (state == lcgrr_pkg::ST_OUT && !out_valid) |=> out_valid)
    else $error("finished result not moved to output");

  // a request starts the remainder unit in the next cycle
  a_div_started: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> div_start)
    else $error("remainder unit not started after request");

endmodule
`default_nettype wire

// ===== tb/lcgrr_checker.sv =====
// checker for the lcg random generator: tracks the seed, predicts and compares results
`timescale 1ns / 1ps
module lcgrr_checker #(
  parameter int unsigned SAMPLE_BITS = lcgrr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [31:0]     cfg_data,
  input  logic            in_valid,
  input  logic            in_ready,
  input  lcgrr_pkg::cmd_t command,
  input  logic [4:0]      bit_count,
  input  logic [31:0]     range_low,
  input  logic [31:0]     range_high,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [31:0]     value,
  output int              fail_count,
  output int              outstanding
);

  localparam logic [31:0] SAMPLE_MASK = (32'd1 << SAMPLE_BITS) - 32'd1;

  // generator state as the block should hold it
  logic [31:0] seed_state;
  logic [31:0] next_seed;
  logic [31:0] want_value;
  logic [31:0] expected_values[$];
  int          results_seen;

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    results_seen = 0;
    seed_state   = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
    fail_count++;
  endtask

  // shape one sample the way the command asks
  function automatic logic [31:0] shape_sample(input lcgrr_pkg::cmd_t cmd,
                                               input logic [4:0] nbits,
                                               input logic [31:0] lo, input logic [31:0] hi,
                                               input logic [31:0] sample);
    logic [31:0] span;
    span = hi - lo + 32'd1;
    case (cmd)
      lcgrr_pkg::CMD_RAW:   return sample;
      lcgrr_pkg::CMD_BITS:
        return (nbits == 5'd0) ? 32'd0 : sample & (32'hFFFF_FFFF >> (32 - nbits));
      lcgrr_pkg::CMD_RANGE: return lo + ((span == 32'd0) ? 32'd0 : sample % span);
      default:              return {31'd0, sample[0]};
    endcase
  endfunction

  // follow seed writes, requests and results at each edge
  always @(posedge clk) begin
    if (rst) begin
      seed_state = '0;
      expected_values.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed_state = cfg_data;
      end
      // results first, so a request taken at the same edge never pairs with it
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("value %08h with no request pending", value));
        end else begin
          want_value = expected_values.pop_front();
          if (value !== want_value) begin
            report_mismatch($sformatf("value %08h, want %08h", value, want_value));
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        next_seed  = seed_state * lcgrr_pkg::LCG_MUL + lcgrr_pkg::LCG_ADD;
        seed_state = next_seed;
        expected_values.push_back(shape_sample(command, bit_count, range_low, range_high,
                                  (next_seed >> lcgrr_pkg::SAMPLE_SHIFT) & SAMPLE_MASK));
      end
    end
    outstanding <= expected_values.size();
  end

endmodule

// ===== tb/lcg_random_with_range_top_tb.sv =====
// testbench top: drives requests and seed writes into the lcg random generator
`timescale 1ns / 1ps
module lcg_random_with_range_top_tb;

  localparam int unsigned LATENCY     = lcgrr_pkg::SAMPLE_BITS_DEFAULT + 3;
  localparam int          PHASE_ITEMS = 300;
  localparam int          NUM_PHASES  = 6;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SENDER      = 0;
  localparam int          RECEIVER    = 1;

  logic            clk        = 1'b0;
  logic            rst        = 1'b1;
  logic            cfg_valid  = 1'b0;
  logic [31:0]     cfg_data   = '0;
  logic            in_valid   = 1'b0;
  lcgrr_pkg::cmd_t command    = lcgrr_pkg::CMD_RAW;
  logic [4:0]      bit_count  = '0;
  logic [31:0]     range_low  = '0;
  logic [31:0]     range_high = '0;
  logic            out_ready  = 1'b0;
  wire             cfg_ready;
  wire             in_ready;
  wire             out_valid;
  wire  [31:0]     value;
  int              fail_count;
  int              outstanding;

  // wait pattern state per side, and the long output hold request
  int wait_left[2];
  bit wait_calm[2];
  bit hold_output = 1'b0;

  lcg_random_with_range_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .bit_count  (bit_count),
    .range_low  (range_low),
    .range_high (range_high),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value)
  );

  lcgrr_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .bit_count   (bit_count),
    .range_low   (range_low),
    .range_high  (range_high),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // hard stop in case the handshakes hang
  initial begin
    #5_000_000;
    $display("[lcg_random_with_range_top] ERROR");
    $finish;
  end

  // waits come in runs: some runs with no gaps at all, others random 0..12
  function automatic int draw_wait(input int side);
    if (wait_left[side] == 0) begin
      wait_calm[side] = ($urandom_range(0, 3) == 0);
      wait_left[side] = $urandom_range(10, 60);
    end
    wait_left[side]--;
    return wait_calm[side] ? 0 : $urandom_range(0, 12);
  endfunction

  // offer one request and wait until it is taken; valid stays high on back-to-back
  task automatic send_request(input lcgrr_pkg::cmd_t cmd, input logic [4:0] nbits,
                              input logic [31:0] lo, input logic [31:0] hi);
    int gap;
    gap = draw_wait(SENDER);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    bit_count  <= nbits;
    range_low  <= lo;
    range_high <= hi;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // receiver: random stalls, plus one long hold when asked
  initial begin
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        stall = draw_wait(RECEIVER);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // stimulus: directed corners on the reset seed, then random phases per seed
  initial begin
    logic [31:0]     phase_seed[NUM_PHASES];
    lcgrr_pkg::cmd_t cmd;
    logic [4:0]      nbits;
    logic [31:0]     lo;
    logic [31:0]     hi;

    phase_seed[0] = 32'h0000_0000;
    phase_seed[1] = 32'hFFFF_FFFF;
    phase_seed[2] = 32'h8000_0000;
    phase_seed[3] = 32'h0000_0001;
    phase_seed[4] = $urandom;
    phase_seed[5] = $urandom;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed requests, seed still at its reset value
    send_request(lcgrr_pkg::CMD_RAW,   5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lcgrr_pkg::CMD_RAW,   5'd0,  32'h0000_0000, 32'h0000_0000);
    send_request(lcgrr_pkg::CMD_BITS,  5'd0,  32'h1234_5678, 32'h0000_0000);
    send_request(lcgrr_pkg::CMD_BITS,  5'd1,  32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lcgrr_pkg::CMD_BITS,  5'd15, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lcgrr_pkg::CMD_BITS,  5'd16, 32'h0000_0000, 32'h0000_0000);
    send_request(lcgrr_pkg::CMD_BITS,  5'd31, 32'hAAAA_AAAA, 32'h5555_5555);
    // full ranges fall back to the lower bound; then one- and two-value ranges
    send_request(lcgrr_pkg::CMD_RANGE, 5'd0,  32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lcgrr_pkg::CMD_RANGE, 5'd31, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lcgrr_pkg::CMD_RANGE, 5'd0,  32'h0000_0005, 32'h0000_0005);
    send_request(lcgrr_pkg::CMD_RANGE, 5'd0,  32'h0000_0000, 32'h0000_0001);
    // signed bounds, reversed bounds, top of the range
    send_request(lcgrr_pkg::CMD_RANGE, 5'd7,  32'hFFFF_FFF6, 32'h0000_000A);
    send_request(lcgrr_pkg::CMD_RANGE, 5'd0,  32'h0000_0064, 32'h0000_000A);
    send_request(lcgrr_pkg::CMD_RANGE, 5'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lcgrr_pkg::CMD_RANGE, 5'd0,  32'h0000_0000, 32'h0000_7FFF);
    send_request(lcgrr_pkg::CMD_RANGE, 5'd0,  32'h0000_0000, 32'hFFFF_FFFE);
    send_request(lcgrr_pkg::CMD_RANGE, 5'd0,  32'hFFFF_FFF0, 32'h0000_000F);
    send_request(lcgrr_pkg::CMD_RANGE, 5'd0,  32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lcgrr_pkg::CMD_BOOL,  5'd31, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lcgrr_pkg::CMD_BOOL,  5'd0,  32'h0000_0000, 32'h0000_0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      // reload the seed while the block is idle
      cfg_valid <= 1'b1;
      cfg_data  <= phase_seed[p];
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 40) begin
          hold_output = 1'b1;
        end
        cmd   = lcgrr_pkg::cmd_t'($urandom_range(0, 3));
        nbits = $urandom_range(0, 31);
        lo    = $urandom;
        case ($urandom_range(0, 5))
          0: hi = lo + $urandom_range(0, 40);
          1: hi = lo + $urandom_range(0, 32'h0001_0000);
          2: hi = $urandom;
          3: hi = lo - 32'd1;
          4: hi = lo - $urandom_range(2, 50);
          default: hi = lo + ($urandom >> $urandom_range(0, 31));
        endcase
        send_request(cmd, nbits, lo, hi);
      end
    end

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("[lcg_random_with_range_top] OK");
    end else begin
      $display("[lcg_random_with_range_top] ERROR");
    end
    $finish;
  end

endmodule
